// ----- rtl/slfr_pkg.sv -----
// ----------------------------------------------------------------------------
// slfr_pkg
// Shared constants for the length-prefixed frame receiver: field widths,
// sync byte, register indexes, status and command codes.
// ----------------------------------------------------------------------------
package slfr_pkg;

    localparam int unsigned BUFFER_BYTES_DEFAULT = 64;

    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned LENGTH_W      = 16;
    localparam int unsigned INFO_W        = 32;
    localparam int unsigned FRAME_BYTES_W = 7;
    localparam int unsigned CODE_W        = 2;
    localparam int unsigned CFG_INDEX_W   = 1;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_CONTROL_CODE  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RESERVED_CODE = 1'd1;

    localparam logic [BYTE_W-1:0] CONTROL_CODE_RESET  = 8'd3;
    localparam logic [BYTE_W-1:0] RESERVED_CODE_RESET = 8'd0;

    // frame_status codes
    localparam logic [CODE_W-1:0] STATUS_GOOD      = 2'd0;
    localparam logic [CODE_W-1:0] STATUS_BAD_FRAME = 2'd1;
    localparam logic [CODE_W-1:0] STATUS_BAD_SUM   = 2'd2;

    // command_kind codes
    localparam logic [CODE_W-1:0] KIND_UNKNOWN  = 2'd0;
    localparam logic [CODE_W-1:0] KIND_CONTROL  = 2'd1;
    localparam logic [CODE_W-1:0] KIND_RESERVED = 2'd2;

endpackage

// ----- rtl/sync_length_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// sync_length_frame_receiver
// Deframes length-prefixed frames (FF FF, 16-bit length, payload, 8-bit sum)
// from a serial byte stream and reports one result per completed frame.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle. Each accepted byte updates the frame
// state in the same cycle and, when it completes a frame, loads the result
// register, so a result appears in the cycle after the last byte of its frame.
// The byte input stalls only while that result register is full and stalled
// downstream. The buffer size BUFFER_BYTES sets where the byte count wraps.
module sync_length_frame_receiver
    import slfr_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration
    input  logic                     cfg_we,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [BYTE_W-1:0]        cfg_wdata,
    // byte input
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [BYTE_W-1:0]        rx_byte,
    // frame result
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [CODE_W-1:0]        frame_status,
    output logic [BYTE_W-1:0]        command_byte,
    output logic [CODE_W-1:0]        command_kind,
    output logic [BYTE_W-1:0]        info_type,
    output logic [INFO_W-1:0]        info_value,
    output logic [FRAME_BYTES_W-1:0] frame_bytes
);

    localparam int unsigned CNT_W = $clog2(BUFFER_BYTES + 1);
    localparam int unsigned EXT_W = (CNT_W > FRAME_BYTES_W) ? CNT_W : FRAME_BYTES_W;

    // configuration
    logic [BYTE_W-1:0]   control_code_reg;
    logic [BYTE_W-1:0]   reserved_code_reg;

    // frame state
    logic [BYTE_W-1:0]   prev_byte_reg;
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic [1:0]          hdr_ok_reg, hdr_ok_next;
    logic [LENGTH_W-1:0] length_reg, length_next;
    logic [BYTE_W-1:0]   cmd_reg,    cmd_next;
    logic [BYTE_W-1:0]   type_reg,   type_next;
    logic [INFO_W-1:0]   info_reg,   info_next;
    logic [BYTE_W-1:0]   sum_reg,    sum_next;

    // result register
    logic                     out_valid_reg;
    logic [CODE_W-1:0]        status_reg,  status_next;
    logic [BYTE_W-1:0]        cmd_out_reg, cmd_out_next;
    logic [CODE_W-1:0]        kind_reg,    kind_next;
    logic [BYTE_W-1:0]        itype_reg,   itype_next;
    logic [INFO_W-1:0]        ival_reg,    ival_next;
    logic [FRAME_BYTES_W-1:0] nbytes_reg,  nbytes_next;

    logic               accept;
    logic               sync_pair;
    logic               fresh;
    logic [CNT_W-1:0]   pos;
    logic [CNT_W-1:0]   n;
    logic [EXT_W-1:0]   n_ext;
    logic [BYTE_W-1:0]  sum_base;
    logic               frame_end;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        sync_pair = (prev_byte_reg == SYNC_BYTE) && (rx_byte == SYNC_BYTE);

        // position of this byte in the frame
        if (sync_pair)
        begin
            pos = CNT_W'(1);
        end
        else if (count_reg >= CNT_W'(BUFFER_BYTES))
        begin
            pos = '0;
        end
        else
        begin
            pos = count_reg;
        end

        // a sync pair restarts the frame as if byte 0 had been an FF
        fresh = sync_pair || (pos == '0);

        hdr_ok_next = fresh ? {1'b0, sync_pair} : hdr_ok_reg;
        sum_base    = fresh ? '0 : sum_reg;
        cmd_next    = fresh ? '0 : cmd_reg;
        type_next   = fresh ? '0 : type_reg;
        info_next   = fresh ? '0 : info_reg;
        length_next = length_reg;

        if (pos == CNT_W'(0))
        begin
            hdr_ok_next[0] = rx_byte == SYNC_BYTE;
        end
        else if (pos == CNT_W'(1))
        begin
            hdr_ok_next[1] = rx_byte == SYNC_BYTE;
        end
        else if (pos == CNT_W'(2))
        begin
            length_next[15:8] = rx_byte;
        end
        else if (pos == CNT_W'(3))
        begin
            length_next[7:0] = rx_byte;
        end
        else if (pos == CNT_W'(4))
        begin
            cmd_next = rx_byte;
        end
        else if (pos == CNT_W'(5))
        begin
            type_next = rx_byte;
        end
        else if (pos <= CNT_W'(9))
        begin
            info_next = {info_next[INFO_W-BYTE_W-1:0], rx_byte};
        end

        n     = pos + CNT_W'(1);
        n_ext = EXT_W'(n);

        frame_end = (n > CNT_W'(3)) &&
                    (({1'b0, length_next} + 17'd4) == 17'(n));

        if (frame_end)
        begin
            count_next = '0;
            sum_next   = sum_base;
        end
        else
        begin
            count_next = n;
            sum_next   = (pos >= CNT_W'(4)) ? (sum_base + rx_byte) : sum_base;
        end

        // result
        if ((hdr_ok_next != 2'b11) || (n < CNT_W'(5)))
        begin
            status_next = STATUS_BAD_FRAME;
        end
        else if (sum_base != rx_byte)
        begin
            status_next = STATUS_BAD_SUM;
        end
        else
        begin
            status_next = STATUS_GOOD;
        end

        kind_next = KIND_UNKNOWN;
        if (status_next == STATUS_GOOD)
        begin
            if (cmd_next == control_code_reg)
            begin
                kind_next = KIND_CONTROL;
            end
            else if (cmd_next == reserved_code_reg)
            begin
                kind_next = KIND_RESERVED;
            end
        end

        cmd_out_next = (n >= CNT_W'(5)) ? cmd_next : '0;

        if ((kind_next == KIND_CONTROL) && (n >= CNT_W'(10)))
        begin
            itype_next = type_next;
            ival_next  = info_next;
        end
        else
        begin
            itype_next = '0;
            ival_next  = '0;
        end

        nbytes_next = n_ext[FRAME_BYTES_W-1:0];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_code_reg  <= CONTROL_CODE_RESET;
            reserved_code_reg <= RESERVED_CODE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CONTROL_CODE:  control_code_reg  <= cfg_wdata;
                REG_RESERVED_CODE: reserved_code_reg <= cfg_wdata;
                default:           control_code_reg  <= control_code_reg;
            endcase
        end
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_byte_reg <= '0;
            count_reg     <= '0;
            hdr_ok_reg    <= '0;
            length_reg    <= '0;
            cmd_reg       <= '0;
            type_reg      <= '0;
            info_reg      <= '0;
            sum_reg       <= '0;
        end
        else if (accept)
        begin
            prev_byte_reg <= rx_byte;
            count_reg     <= count_next;
            hdr_ok_reg    <= hdr_ok_next;
            length_reg    <= length_next;
            cmd_reg       <= cmd_next;
            type_reg      <= type_next;
            info_reg      <= info_next;
            sum_reg       <= sum_next;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && frame_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept && frame_end)
        begin
            status_reg  <= status_next;
            cmd_out_reg <= cmd_out_next;
            kind_reg    <= kind_next;
            itype_reg   <= itype_next;
            ival_reg    <= ival_next;
            nbytes_reg  <= nbytes_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_status = status_reg;
    assign command_byte = cmd_out_reg;
    assign command_kind = kind_reg;
    assign info_type    = itype_reg;
    assign info_value   = ival_reg;
    assign frame_bytes  = nbytes_reg;

endmodule

// ----- rtl/slfr_checker.sv -----
// ----------------------------------------------------------------------------
// slfr_checker
// Port-level checks on the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module slfr_checker
    import slfr_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_stall,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic [CODE_W-1:0]        frame_status,
    input logic [BYTE_W-1:0]        command_byte,
    input logic [CODE_W-1:0]        command_kind,
    input logic [BYTE_W-1:0]        info_type,
    input logic [INFO_W-1:0]        info_value,
    input logic [FRAME_BYTES_W-1:0] frame_bytes
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_status) &&
        $stable(command_byte) && $stable(command_kind) && $stable(info_type) &&
        $stable(info_value) && $stable(frame_bytes))
        else $error("result changed while stalled");

    // input only backs up behind a full result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with result register empty");

    // a rejected frame carries no decoded command
    a_bad_no_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (frame_status != STATUS_GOOD) |-> command_kind == KIND_UNKNOWN)
        else $error("command kind reported for a bad frame");

    // info fields belong to control frames only
    a_info_control: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (command_kind != KIND_CONTROL) |-> (info_type == '0) &&
        (info_value == '0))
        else $error("info reported for a non-control frame");

endmodule

bind sync_length_frame_receiver slfr_checker u_slfr_checker (.*);
